// ----- sv/acdb_pkg.sv -----
// acdb_pkg: shared constants for the audio capture dc blocker
// register indexes, reset values and default widths; no dependencies
package acdb_pkg;

  localparam int SAMPLE_BITS_DEFAULT         = 24;
  localparam int STATE_FRACTION_BITS_DEFAULT = 8;

  localparam int FRAME_BITS  = 32;
  localparam int HALF_BITS   = 16;
  localparam int STATE_BITS  = 32;
  localparam int POLE_BITS   = 15;
  localparam int INDEX_BITS  = 16;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_CAPTURE_ENABLE   = 2'd0,
    REG_POLE_COEFFICIENT = 2'd1,
    REG_CHUNK_LENGTH     = 2'd2
  } cfg_reg_t;

  localparam logic [POLE_BITS-1:0]  POLE_RESET  = 15'd32604;
  localparam logic [INDEX_BITS-1:0] CHUNK_RESET = 16'd8000;

endpackage

// ----- sv/acdb_stream_if.sv -----
// acdb_stream_if: valid/ready channels for frame words and filtered results
// depends on acdb_pkg for field widths
interface acdb_in_if;
  logic                           valid;
  logic                           ready;
  logic [acdb_pkg::HALF_BITS-1:0] word_high;
  logic [acdb_pkg::HALF_BITS-1:0] word_low;

  modport source (output valid, output word_high, output word_low, input ready);
  modport sink   (input valid, input word_high, input word_low, output ready);
endinterface

interface acdb_out_if #(
  parameter int SAMPLE_BITS = acdb_pkg::SAMPLE_BITS_DEFAULT
);
  logic                            valid;
  logic                            ready;
  logic signed [SAMPLE_BITS-1:0]   filtered_sample;
  logic [acdb_pkg::INDEX_BITS-1:0] write_index;
  logic                            buffer_select;
  logic                            chunk_done;

  modport source (output valid, output filtered_sample, output write_index,
                  output buffer_select, output chunk_done, input ready);
  modport sink   (input valid, input filtered_sample, input write_index,
                  input buffer_select, input chunk_done, output ready);
endinterface

// ----- sv/audio_capture_dc_blocker.sv -----
// audio_capture_dc_blocker: frame join, first-order dc blocker, ping-pong indexing
// depends on acdb_pkg and the channel interfaces in acdb_stream_if.sv
//
// usage
//   sample_in carries one frame per word: word_high then word_low, joined as a
//   32-bit two's complement frame and shifted down to a SAMPLE_BITS sample
//   result_out carries one filtered sample per word, tagged with its position in
//   the current chunk, the ping-pong half and a chunk done flag
//   cfg_write/cfg_index/cfg_data write capture enable, pole and chunk length;
//   write only while no word is in flight
//   latency: one cycle from an accepted frame to its result word
//   throughput: one frame per cycle; the filter feedback (one 32x16 multiply,
//   one add and saturation) closes in a single cycle, so frames may follow
//   back to back
//   while capture is disabled frames are accepted and dropped, state untouched
//   when the receiver stalls the result register holds and sample_in.ready
//   drops, unless the result is taken in that same cycle
//   reset clears filter state, index, half and the result valid, and loads
//   the register reset values (capture off, pole 32604, chunk 8000)
module audio_capture_dc_blocker #(
  parameter int SAMPLE_BITS         = acdb_pkg::SAMPLE_BITS_DEFAULT,
  parameter int STATE_FRACTION_BITS = acdb_pkg::STATE_FRACTION_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [acdb_pkg::CFG_ADDR_BITS-1:0] cfg_index,
  input  logic [acdb_pkg::CFG_DATA_BITS-1:0] cfg_data,
  acdb_in_if.sink                            sample_in,
  acdb_out_if.source                         result_out
);

  localparam int SB  = SAMPLE_BITS;
  localparam int FB  = STATE_FRACTION_BITS;
  localparam int STW = acdb_pkg::STATE_BITS;
  localparam int PW  = acdb_pkg::POLE_BITS;
  // product of state and pole, pole taken as a positive signed value
  localparam int MW  = STW + PW + 1;
  // feedback term after the Q0.15 rounding shift
  localparam int FW  = MW - PW;
  // unsaturated new state
  localparam int DW  = SB + 1 + FB;
  localparam int YW  = ((DW > FW) ? DW : FW) + 1;
  // rounded output before sample saturation
  localparam int OW  = STW + 2;

  localparam logic signed [MW-1:0] POLE_ROUND = MW'(1) <<< (PW - 1);
  localparam logic signed [STW:0]  OUT_ROUND  =
    (FB > 0) ? ((STW + 1)'(1) <<< ((FB > 0) ? FB - 1 : 0)) : '0;
  localparam logic signed [YW-1:0] Y_MAX = YW'({1'b0, {(STW - 1){1'b1}}});
  localparam logic signed [YW-1:0] Y_MIN = -YW'(Y_MAX) - YW'(1);
  localparam logic signed [OW-1:0] S_MAX = OW'({1'b0, {(SB - 1){1'b1}}});
  localparam logic signed [OW-1:0] S_MIN = -OW'(S_MAX) - OW'(1);

  // configuration registers
  logic                             capture_enable;
  logic [PW-1:0]                    pole_coefficient;
  logic [acdb_pkg::INDEX_BITS-1:0]  chunk_length;

  // filter and chunk state
  logic signed [SB-1:0]             previous_input;
  logic signed [STW-1:0]            previous_output;
  logic [acdb_pkg::INDEX_BITS-1:0]  sample_position;
  logic                             active_half;

  // result register
  logic                             out_valid;
  logic signed [SB-1:0]             out_sample;
  logic [acdb_pkg::INDEX_BITS-1:0]  out_index;
  logic                             out_half;
  logic                             out_done;

  logic                             accept;
  logic                             take;
  logic [acdb_pkg::FRAME_BITS-1:0]  frame;
  logic signed [SB-1:0]             x;
  logic signed [MW-1:0]             product;
  logic signed [MW-1:0]             product_rnd;
  logic signed [FW-1:0]             feedback;
  logic signed [SB:0]               diff;
  logic signed [YW-1:0]             y_full;
  logic signed [STW-1:0]            y_sat;
  logic signed [STW:0]              y_rnd;
  logic signed [OW-1:0]             o_full;
  logic signed [SB-1:0]             o_sat;
  logic [acdb_pkg::INDEX_BITS:0]    pos_inc;
  logic                             done;

  // room in the result register when empty or being drained this cycle
  assign sample_in.ready = !out_valid || result_out.ready;
  assign accept          = sample_in.valid && sample_in.ready;
  assign take            = accept && capture_enable;

  always_comb begin
    frame   = {sample_in.word_high, sample_in.word_low};
    // arithmetic shift down keeps the top SB bits
    x       = $signed(frame[acdb_pkg::FRAME_BITS-1 -: SB]);

    // a * y_prev, rounded half up in Q0.15
    product     = MW'(previous_output) * $signed({1'b0, pole_coefficient});
    product_rnd = product + POLE_ROUND;
    feedback    = product_rnd[MW-1:PW];

    diff   = (SB + 1)'(x) - (SB + 1)'(previous_input);
    y_full = (YW'(diff) <<< FB) + YW'(feedback);

    // state saturates at 32 bits
    if (y_full > Y_MAX) begin
      y_sat = STW'(Y_MAX);
    end else if (y_full < Y_MIN) begin
      y_sat = STW'(Y_MIN);
    end else begin
      y_sat = y_full[STW-1:0];
    end

    // round to an integer sample, then saturate to the sample width
    y_rnd  = (STW + 1)'(y_sat) + OUT_ROUND;
    o_full = OW'(y_rnd >>> FB);
    if (o_full > S_MAX) begin
      o_sat = SB'(S_MAX);
    end else if (o_full < S_MIN) begin
      o_sat = SB'(S_MIN);
    end else begin
      o_sat = o_full[SB-1:0];
    end

    // chunk ends once position + 1 reaches the length; zero length ends every sample
    pos_inc = {1'b0, sample_position} + 1'b1;
    done    = pos_inc >= {1'b0, chunk_length};
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable   <= 1'b0;
      pole_coefficient <= acdb_pkg::POLE_RESET;
      chunk_length     <= acdb_pkg::CHUNK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        acdb_pkg::REG_CAPTURE_ENABLE:   capture_enable   <= cfg_data[0];
        acdb_pkg::REG_POLE_COEFFICIENT: pole_coefficient <= cfg_data[PW-1:0];
        acdb_pkg::REG_CHUNK_LENGTH:     chunk_length     <= cfg_data;
        default: ;
      endcase
    end
  end

  // filter state and chunk position
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_input  <= '0;
      previous_output <= '0;
      sample_position <= '0;
      active_half     <= 1'b0;
    end else if (take) begin
      if (done) begin
        previous_input  <= '0;
        previous_output <= '0;
        sample_position <= '0;
        active_half     <= !active_half;
      end else begin
        previous_input  <= x;
        previous_output <= y_sat;
        sample_position <= pos_inc[acdb_pkg::INDEX_BITS-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sample_in.ready) begin
      out_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_sample <= o_sat;
      out_index  <= sample_position;
      out_half   <= active_half;
      out_done   <= done;
    end
  end

  assign result_out.valid           = out_valid;
  assign result_out.filtered_sample = out_sample;
  assign result_out.write_index     = out_index;
  assign result_out.buffer_select   = out_half;
  assign result_out.chunk_done      = out_done;

endmodule

// ----- tb/audio_capture_dc_blocker_tb.sv -----
// audio_capture_dc_blocker_tb: self-checking bench for the audio capture front end
// drives frames and register writes, predicts each filtered word and checks it
// depends on acdb_pkg, acdb_stream_if.sv and audio_capture_dc_blocker.sv
module audio_capture_dc_blocker_tb;

  localparam int SAMPLE_W      = acdb_pkg::SAMPLE_BITS_DEFAULT;
  localparam int FRAC_W        = acdb_pkg::STATE_FRACTION_BITS_DEFAULT;
  localparam int RANDOM_FRAMES = 1500;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT  = 10;

  // saturation bounds of the filter state and of the output sample
  localparam longint STATE_MAX  = 64'sd2147483647;
  localparam longint STATE_MIN  = -64'sd2147483648;
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_W - 1));

  // one result word as the block should present it
  typedef struct packed {
    logic signed [SAMPLE_W-1:0]          sample;
    logic [acdb_pkg::INDEX_BITS-1:0]     index;
    logic                                half;
    logic                                done;
  } capture_word_t;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               cfg_write;
  logic [acdb_pkg::CFG_ADDR_BITS-1:0] cfg_index;
  logic [acdb_pkg::CFG_DATA_BITS-1:0] cfg_data;

  acdb_in_if                             in_ch ();
  acdb_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_ch ();

  audio_capture_dc_blocker #(
    .SAMPLE_BITS        (SAMPLE_W),
    .STATE_FRACTION_BITS(FRAC_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_in (in_ch),
    .result_out(out_ch)
  );

  // shadow copy of the registers
  logic                            enable_q;
  logic [acdb_pkg::POLE_BITS-1:0]  pole_q;
  logic [acdb_pkg::INDEX_BITS-1:0] chunk_len_q;

  // shadow copy of the filter and chunk state
  longint                          last_sample;   // previous input sample x
  longint                          last_state;    // previous y, FRAC_W fraction bits
  logic [acdb_pkg::INDEX_BITS-1:0] position;      // next write index
  logic                            half_q;        // active ping-pong half

  // result words still owed by the block, oldest first
  capture_word_t pending_words[$];

  int failures = 0;
  bit input_gaps_on    = 1'b1;
  bit output_stalls_on = 1'b1;

  always #2 clk = ~clk;

  // filter one accepted frame and advance the shadow state
  function automatic capture_word_t filter_frame(
    input logic [acdb_pkg::HALF_BITS-1:0] hi,
    input logic [acdb_pkg::HALF_BITS-1:0] lo);
    logic signed [acdb_pkg::FRAME_BITS-1:0] frame;
    longint                                 x;
    longint                                 fb;
    longint                                 y;
    longint                                 o;
    capture_word_t                          r;
    frame = {hi, lo};
    // arithmetic shift is a floor, so the dropped low byte rounds toward minus infinity
    x  = longint'(frame) >>> (acdb_pkg::FRAME_BITS - SAMPLE_W);
    // feedback a * y_prev in q0.15, rounded half up
    fb = (last_state * longint'(pole_q) + (longint'(1) <<< (acdb_pkg::POLE_BITS - 1)))
         >>> acdb_pkg::POLE_BITS;
    y  = (x - last_sample) * (longint'(1) <<< FRAC_W) + fb;
    if (y > STATE_MAX) y = STATE_MAX;
    if (y < STATE_MIN) y = STATE_MIN;
    // drop the fraction bits, rounded half up, then clip to the sample width
    if (FRAC_W > 0) o = (y + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    else o = y;
    if (o > SAMPLE_MAX) o = SAMPLE_MAX;
    if (o < SAMPLE_MIN) o = SAMPLE_MIN;

    r.sample = o[SAMPLE_W-1:0];
    r.index  = position;
    r.half   = half_q;
    // a length at or below the position (lowered mid-chunk, or zero) ends the chunk now
    r.done   = (32'(position) + 32'd1) >= 32'(chunk_len_q);

    last_sample = x;
    last_state  = y;
    if (r.done) begin
      half_q      = ~half_q;
      position    = '0;
      last_sample = 0;
      last_state  = 0;
    end else begin
      position = position + 1'b1;
    end
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want)
      note_failure($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
  endfunction

  // register write, only called while nothing is in flight
  task automatic write_register(input acdb_pkg::cfg_reg_t which,
                                input logic [acdb_pkg::CFG_DATA_BITS-1:0] value);
    cfg_write = 1'b1;
    cfg_index = which;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    case (which)
      acdb_pkg::REG_CAPTURE_ENABLE:   enable_q    = value[0];
      acdb_pkg::REG_POLE_COEFFICIENT: pole_q      = value[acdb_pkg::POLE_BITS-1:0];
      acdb_pkg::REG_CHUNK_LENGTH:     chunk_len_q = value;
      default: ;
    endcase
  endtask

  // send one frame word; called and returns at a falling edge
  task automatic send_frame(input logic [acdb_pkg::HALF_BITS-1:0] hi,
                            input logic [acdb_pkg::HALF_BITS-1:0] lo);
    int gap;
    int pick;
    gap = 0;
    if (input_gaps_on) begin
      pick = $urandom_range(0, 99);
      if (pick >= 90) gap = $urandom_range(5, 30);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.word_high = hi;
    in_ch.word_low  = lo;
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // frames taken while capture is off are dropped and leave the state alone
    if (enable_q) pending_words.push_back(filter_frame(hi, lo));
    @(negedge clk);
  endtask

  // stop sending and wait until every owed word has come out
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // frames straight out of reset are dropped, capture starts off
  task automatic test_capture_disabled();
    send_frame(16'h1234, 16'h5600);
    send_frame(16'h8000, 16'h0000);
    drain_results();
    write_register(acdb_pkg::REG_CAPTURE_ENABLE, 16'd1);
  endtask

  // extremes of both half-words, including the ignored low byte
  task automatic test_frame_extremes();
    logic [acdb_pkg::FRAME_BITS-1:0] frames [6];
    frames = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h0000_00FF, 32'h0000_0100};
    foreach (frames[i]) send_frame(frames[i][31:16], frames[i][15:0]);
  endtask

  // full-scale swings with the largest pole push the state into saturation
  task automatic test_state_saturation();
    drain_results();
    write_register(acdb_pkg::REG_POLE_COEFFICIENT, 16'd32767);
    send_frame(16'h8000, 16'h0000);
    send_frame(16'h7FFF, 16'hFF00);
    send_frame(16'h8000, 16'h0000);
  endtask

  // no feedback at all
  task automatic test_zero_pole();
    drain_results();
    write_register(acdb_pkg::REG_POLE_COEFFICIENT, 16'd0);
    send_frame(16'h0040, 16'h0000);
    send_frame(16'hFFC0, 16'h0000);
  endtask

  // chunk ends: length one, length zero, length lowered below the index, longest length
  task automatic test_chunk_ends();
    drain_results();
    write_register(acdb_pkg::REG_CHUNK_LENGTH, 16'd1);
    send_frame(16'h0100, 16'h0000);
    drain_results();
    write_register(acdb_pkg::REG_CHUNK_LENGTH, 16'd0);
    send_frame(16'h0200, 16'h0000);
    send_frame(16'hFE00, 16'h0000);
    drain_results();
    write_register(acdb_pkg::REG_CHUNK_LENGTH, 16'd5);
    repeat (3) send_frame(16'h0300, 16'h8000);
    drain_results();
    // index is now 3, so the next word must close the chunk at index 3
    write_register(acdb_pkg::REG_CHUNK_LENGTH, 16'd2);
    send_frame(16'h0400, 16'h0000);
    drain_results();
    write_register(acdb_pkg::REG_CHUNK_LENGTH, 16'hFFFF);
    send_frame(16'h0500, 16'h0000);
  endtask

  // phases of random frames, each under a fresh register setting; every phase
  // starts with the sender holding off until all owed words are back
  task automatic test_random_phases();
    int                                 counted;
    int                                 burst;
    int                                 pick;
    logic [acdb_pkg::HALF_BITS-1:0]     hi;
    logic [acdb_pkg::HALF_BITS-1:0]     lo;
    logic [acdb_pkg::CFG_DATA_BITS-1:0] value;
    counted = 0;
    while (counted < RANDOM_FRAMES) begin
      drain_results();
      value = ($urandom_range(0, 9) != 0) ? 16'd1 : 16'd0;
      write_register(acdb_pkg::REG_CAPTURE_ENABLE, value);

      pick = $urandom_range(0, 9);
      if (pick == 0) value = 16'd0;
      else if (pick == 1) value = 16'd32767;
      else value = 16'($urandom_range(0, 32767));
      write_register(acdb_pkg::REG_POLE_COEFFICIENT, value);

      // mostly short chunks so the halves flip often; a shorter length than
      // the current index gives the lowered-length case
      pick = $urandom_range(0, 9);
      if (pick <= 6) value = 16'($urandom_range(1, 40));
      else if (pick == 7) value = 16'd0;
      else if (pick == 8) value = 16'($urandom_range(41, 65535));
      else value = 16'hFFFF;
      write_register(acdb_pkg::REG_CHUNK_LENGTH, value);

      input_gaps_on    = ($urandom_range(0, 3) != 0);
      output_stalls_on = ($urandom_range(0, 3) != 0);

      burst = $urandom_range(5, 80);
      repeat (burst) begin
        hi = 16'($urandom_range(0, 16'hFFFF));
        lo = 16'($urandom_range(0, 16'hFFFF));
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0: hi = 16'h7FFF;
            1: hi = 16'h8000;
            2: hi = 16'hFFFF;
            default: hi = 16'h0000;
          endcase
        end
        send_frame(hi, lo);
      end
      if (enable_q) counted += burst;
    end
    input_gaps_on    = 1'b1;
    output_stalls_on = 1'b1;
  endtask

  // receiver side: random stalls, mostly short, a few long
  initial begin : result_ready_driver
    int stall_left;
    int pick;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else if (!output_stalls_on) begin
        out_ch.ready = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          out_ch.ready = 1'b1;
        end else begin
          out_ch.ready = 1'b0;
          stall_left   = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        end
      end
    end
  end

  // compare every accepted result word with the oldest owed word
  always @(posedge clk) begin : result_checker
    capture_word_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_words.size() == 0) begin
        note_failure($sformatf("unexpected result word: sample 0x%0h index %0d",
                               out_ch.filtered_sample, out_ch.write_index));
      end else begin
        want = pending_words.pop_front();
        check_field("filtered_sample", 32'(want.sample), 32'(out_ch.filtered_sample));
        check_field("write_index", 32'(want.index), 32'(out_ch.write_index));
        check_field("buffer_select", 32'(want.half), 32'(out_ch.buffer_select));
        check_field("chunk_done", 32'(want.done), 32'(out_ch.chunk_done));
      end
    end
  end

  // cycle counter guarding against a hung handshake
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("audio_capture_dc_blocker verification failed");
    $finish;
  end

  initial begin : stimulus
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = acdb_pkg::REG_CAPTURE_ENABLE;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.word_high = '0;
    in_ch.word_low  = '0;

    // shadow state as reset leaves it
    enable_q    = 1'b0;
    pole_q      = acdb_pkg::POLE_RESET;
    chunk_len_q = acdb_pkg::CHUNK_RESET;
    last_sample = 0;
    last_state  = 0;
    position    = '0;
    half_q      = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_capture_disabled();
    test_frame_extremes();
    test_state_saturation();
    test_zero_pole();
    test_chunk_ends();
    test_random_phases();
    drain_results();

    if (failures == 0 && pending_words.size() == 0) begin
      $display("audio_capture_dc_blocker verification clean");
    end else begin
      $display("audio_capture_dc_blocker verification failed");
    end
    $finish;
  end

endmodule
